@@ rtl/tmh_pkg.sv @@
// Package with the shared types and constants of the timer min-heap.
package tmh_pkg;
   localparam int HeapDepth    = 16;
   localparam int SecondsWidth = 32;
   localparam int IdWidth      = 4;
   localparam int IdCount      = 16;
   localparam int MicrosWidth  = 20;
   localparam int SlotWidth    = $clog2(HeapDepth);
   localparam int CountWidth   = $clog2(HeapDepth + 1);
   localparam int KeyWidth     = SecondsWidth + MicrosWidth;
   localparam int EntryWidth   = KeyWidth + IdWidth;

   typedef logic [CountWidth-1:0] count_type;
   typedef logic [SlotWidth-1:0]  slot_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_ABSENT  = 2'd2,
      STATUS_PRESENT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SIFT  = 2'd1,
      ST_DONE  = 2'd2
   } state_type;

   typedef enum logic {
      FUNC_PUSH  = 1'b0,
      FUNC_ERASE = 1'b1
   } func_type;

   // One heap entry: key first, so that a plain compare orders keys.
   typedef struct packed {
      logic [SecondsWidth-1:0] seconds;
      logic [MicrosWidth-1:0]  micros;
      logic [IdWidth-1:0]      id;
   } entry_type;

   // Control word broadcast from the sequencer to every cell.
   typedef struct packed {
      logic      load;
      logic      sift;
      logic      erase;
      slot_type  target;
      entry_type word;
   } cell_ctrl_type;

   // True when key a is strictly later than key b.
   function automatic logic later(entry_type a, entry_type b);
      later = {a.seconds, a.micros} > {b.seconds, b.micros};
   endfunction
endpackage

@@ rtl/tmh_cell.sv @@
// One heap slot: holds an entry and swaps with its parent or child.
module tmh_cell (
   input  logic                    clock,
   input  tmh_pkg::cell_ctrl_type  ctrl,
   input  logic [tmh_pkg::SlotWidth-1:0] slot,
   input  tmh_pkg::entry_type      parent_word,
   input  tmh_pkg::entry_type      left_word,
   input  tmh_pkg::entry_type      right_word,
   input  tmh_pkg::entry_type      last_word,
   input  logic                    up_swap,
   input  logic                    down_left,
   input  logic                    down_right,
   input  logic                    parent_down_self,
   input  logic                    child_up,
   output tmh_pkg::entry_type      word
);
   import tmh_pkg::*;
   entry_type word_ff, word_in;

   // Next entry: load, or exchange with a neighbour on a sift step.
   always_comb begin
      word_in = word_ff;
      if (ctrl.load && ctrl.target == slot) begin
         word_in = ctrl.erase ? last_word : ctrl.word;
      end else if (ctrl.sift) begin
         if (up_swap) word_in = parent_word;
         else if (child_up) word_in = (down_left ? left_word : right_word);
         else if (down_left) word_in = left_word;
         else if (down_right) word_in = right_word;
         else if (parent_down_self) word_in = parent_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
endmodule

@@ rtl/timer_min_heap_top.sv @@
// Top level of the timer min-heap: sequencer, id table and a row of cells.
// An accepted item takes at most one sift step per cycle through the cell row
// before the strobe; a rejected item goes straight from acceptance to the
// strobe.
// Throughput: one item at a time; busy is high from acceptance to the strobe.
// Reset clears the count, the id table and the sequencer; slots hold junk
// until written. The receiver cannot stall: rsp_valid lasts one cycle.
module timer_min_heap_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [3:0]  req_event_id,
   input  logic [31:0] req_key_seconds,
   input  logic [19:0] req_key_micros,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic        rsp_top_valid,
   output logic [3:0]  rsp_top_id,
   output logic [31:0] rsp_top_seconds,
   output logic [19:0] rsp_top_micros,
   output logic [4:0]  rsp_entry_total
);
   import tmh_pkg::*;

   state_type     state_ff, state_in;
   count_type     count_ff, count_in;
   slot_type      pos_ff, pos_in;
   logic          up_ff, up_in;
   logic          erase_ff, erase_in;
   status_type    status_ff, status_in;
   logic [IdCount-1:0]   present_ff, present_in;
   slot_type      slot_of_ff [IdCount];
   cell_ctrl_type ctrl;
   entry_type     words [HeapDepth];
   entry_type     last_word;
   logic          step_up, step_left, step_right;
   slot_type      parent_pos, left_pos, right_pos;
   logic          load;
   logic          cont;

   // Neighbours of the slot being sifted, and the last occupied slot.
   always_comb begin
      parent_pos = slot_type'((32'(pos_ff) - 32'd1) >> 1);
      left_pos   = slot_type'(2 * 32'(pos_ff) + 1);
      right_pos  = slot_type'(2 * 32'(pos_ff) + 2);
      last_word  = words[slot_type'(count_ff - count_type'(1))];
   end

   // Decide the sift step for the current slot.
   always_comb begin
      logic [31:0] r;
      logic pick_l;
      r = 2 * 32'(pos_ff) + 2;
      step_up = 1'b0;
      step_left = 1'b0;
      step_right = 1'b0;
      pick_l = 1'b0;
      if (up_ff) begin
         step_up = (pos_ff != '0) && later(words[parent_pos], words[pos_ff]);
      end else if (r <= 32'(count_ff)) begin
         pick_l = (r == 32'(count_ff)) || later(words[right_pos], words[left_pos]);
         if (pick_l) step_left = later(words[pos_ff], words[left_pos]);
         else step_right = later(words[pos_ff], words[right_pos]);
      end
   end

   assign cont = step_up || step_left || step_right;
   assign load = (state_ff == ST_IDLE) && start && (status_in == STATUS_OK);

   // Control word to the cells.
   always_comb begin
      ctrl.load   = load;
      ctrl.sift   = (state_ff == ST_SIFT) && cont;
      ctrl.erase  = req_func == FUNC_ERASE;
      ctrl.word   = '{seconds: req_key_seconds, micros: req_key_micros,
                      id: req_event_id};
      ctrl.target = (req_func == FUNC_PUSH) ? slot_type'(count_ff)
                                            : slot_of_ff[req_event_id];
   end

   // The row of cells. On an upward step the parent takes the word of the
   // child being sifted; odd slots are left children.
   for (genvar i = 0; i < HeapDepth; i++) begin : g_cell
      localparam int P = (i == 0) ? 0 : (i - 1) / 2;
      localparam int L = (2 * i + 1 < HeapDepth) ? 2 * i + 1 : i;
      localparam int R = (2 * i + 2 < HeapDepth) ? 2 * i + 2 : i;
      logic me;
      logic up_to_me;
      assign me = pos_ff == slot_type'(i);
      assign up_to_me = step_up && parent_pos == slot_type'(i);
      tmh_cell u_cell (
         .clock            (clock),
         .ctrl             (ctrl),
         .slot             (slot_type'(i)),
         .parent_word      (words[P]),
         .left_word        (words[L]),
         .right_word       (words[R]),
         .last_word        (last_word),
         .up_swap          (me && step_up),
         .down_left        ((me && step_left) || (up_to_me && pos_ff[0])),
         .down_right       (me && step_right),
         .parent_down_self ((step_left && left_pos == slot_type'(i)) ||
                            (step_right && right_pos == slot_type'(i))),
         .child_up         (up_to_me),
         .word             (words[i])
      );
   end

   // Sequencer: next state and item bookkeeping.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      up_in      = up_ff;
      erase_in   = erase_ff;
      status_in  = status_ff;
      present_in = present_ff;
      if (state_ff == ST_IDLE) begin
         if (req_func == FUNC_PUSH) begin
            if (present_ff[req_event_id]) status_in = STATUS_PRESENT;
            else if (32'(count_ff) >= HeapDepth) status_in = STATUS_FULL;
            else status_in = STATUS_OK;
         end else begin
            status_in = present_ff[req_event_id] ? STATUS_OK : STATUS_ABSENT;
         end
         if (start) begin
            state_in = ST_DONE;
            erase_in = req_func;
            if (status_in == STATUS_OK) begin
               state_in = ST_SIFT;
               if (req_func == FUNC_PUSH) begin
                  pos_in = slot_type'(count_ff);
                  up_in  = 1'b1;
                  count_in = count_ff + count_type'(1);
                  present_in[req_event_id] = 1'b1;
               end else begin
                  pos_in = slot_of_ff[req_event_id];
                  count_in = count_ff - count_type'(1);
                  present_in[req_event_id] = 1'b0;
                  if (slot_of_ff[req_event_id] >= slot_type'(count_ff - count_type'(1))
                      || 32'(count_ff) == 1)
                     state_in = ST_DONE;
                  up_in = 1'b1;
               end
            end
         end
      end else if (state_ff == ST_SIFT) begin
         // An erase that did not move up turns to sifting down, even at the root.
         if (step_up) pos_in = parent_pos;
         else if (step_left) pos_in = left_pos;
         else if (step_right) pos_in = right_pos;
         else if (up_ff && erase_ff) up_in = 1'b0;
         else state_in = ST_DONE;
         if (cont && up_ff) erase_in = 1'b0;
      end else begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         present_ff <= '0;
         pos_ff     <= '0;
         up_ff      <= 1'b0;
         erase_ff   <= 1'b0;
         status_ff  <= STATUS_OK;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         present_ff <= present_in;
         pos_ff     <= pos_in;
         up_ff      <= up_in;
         erase_ff   <= erase_in;
         status_ff  <= status_in;
      end
   end

   // Position table, rebuilt from the cell row after every change.
   always_ff @(posedge clock) begin
      for (int i = 0; i < HeapDepth; i++) begin
         if (32'(i) < 32'(count_ff)) slot_of_ff[words[i].id] <= slot_type'(i);
      end
   end

   // Result outputs.
   always_comb begin
      busy            = state_ff != ST_IDLE;
      rsp_valid       = state_ff == ST_DONE;
      rsp_status      = status_ff;
      rsp_top_valid   = count_ff != '0;
      rsp_top_id      = rsp_top_valid ? words[0].id : '0;
      rsp_top_seconds = rsp_top_valid ? words[0].seconds : '0;
      rsp_top_micros  = rsp_top_valid ? words[0].micros : '0;
      rsp_entry_total = count_ff;
   end
endmodule
